>>> hw/rtl/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types, codes and helpers for the periodic timer bank.
// ----------------------------------------------------------------------------
package ptb_pkg;

	localparam int NUM_TIMERS = 8;
	localparam int COUNT_BITS = 24;
	localparam int ID_BITS    = 16;
	localparam int SLOT_BITS  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [ID_BITS-1:0]    ident_t;
	typedef logic [SLOT_BITS-1:0]  slot_t;

	typedef enum logic [2:0] {
		CMD_TICK   = 3'd0,
		CMD_CHECK  = 3'd1,
		CMD_ADD    = 3'd2,
		CMD_REMOVE = 3'd3,
		CMD_DELAY  = 3'd4
	} cmd_t;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_FULL      = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LAST
	} state_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [23:0] period;
		logic [15:0] timer_id;
		logic [23:0] delay_ticks;
	} req_t;

	typedef struct packed {
		logic        fired;
		logic [15:0] fired_id;
		logic [15:0] assigned_id;
		logic [1:0]  status;
		logic        delay_busy;
	} rsp_t;

	// one slot of the table as held in the ram
	typedef struct packed {
		count_t period;
		count_t count;
		ident_t ident;
	} entry_t;

	typedef struct packed {
		logic   en;
		slot_t  addr;
		entry_t data;
	} ram_wr_t;

	typedef struct packed {
		logic  en;
		slot_t addr;
	} ram_rd_t;

	// first set bit of act, searching upward from slot "from" around the ring
	function automatic logic [SLOT_BITS:0] ring_first(
		logic [NUM_TIMERS-1:0] act,
		slot_t                 from
	);
		logic [SLOT_BITS:0] res;
		int                 s;
		res = '0;
		for (int k = NUM_TIMERS - 1; k >= 0; k--) begin
			s = int'(from) + k;
			if (s >= NUM_TIMERS) s = s - NUM_TIMERS;
			if (act[s]) res = {1'b1, SLOT_BITS'(s)};
		end
		return res;
	endfunction

	// lowest clear bit of act
	function automatic logic [SLOT_BITS:0] lowest_free(logic [NUM_TIMERS-1:0] act);
		logic [SLOT_BITS:0] res;
		res = '0;
		for (int k = NUM_TIMERS - 1; k >= 0; k--) begin
			if (!act[k]) res = {1'b1, SLOT_BITS'(k)};
		end
		return res;
	endfunction

endpackage

>>> hw/rtl/ptb_slot_ram.sv
// ----------------------------------------------------------------------------
// ptb_slot_ram
// Slot table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ptb_slot_ram (
	input  logic             clk,
	input  ptb_pkg::ram_wr_t wr,
	input  ptb_pkg::ram_rd_t rd,
	output ptb_pkg::entry_t  rdata
);

	ptb_pkg::entry_t mem [ptb_pkg::NUM_TIMERS];

	always_ff @(posedge clk) begin
		if (wr.en) mem[wr.addr] <= wr.data;
	end

	always_ff @(posedge clk) begin
		if (rd.en) rdata <= mem[rd.addr];
	end

endmodule

>>> hw/rtl/periodic_timer_bank.sv
// ----------------------------------------------------------------------------
// periodic_timer_bank
// Bank of periodic timers with a shared delay counter, one command per request.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake               payload
// request   in         start high, busy low    request (ptb_pkg::req_t)
// result    out        done high for one cycle result  (ptb_pkg::rsp_t)
//
// add, start delay and unused codes, and a check with no active timer, finish
// at accept; a check that finds a timer reads its one slot; tick and remove
// walk every slot through the single read port of the slot ram, one slot per
// cycle. busy is high from the cycle after a walk is accepted and falls in
// the cycle done is shown; requests finished at accept never raise busy.
// reset clears the active bits, id counter, round-robin pointer, delay count
// and the sequencer; slot ram contents stay unknown until written by an add.
// the receiver cannot stall: every result is shown for exactly one cycle.
//
module periodic_timer_bank (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ptb_pkg::req_t request,
	output logic          done,
	output ptb_pkg::rsp_t result
);

	// sequencer and request registers
	ptb_pkg::state_t state_q, state_d;
	logic [2:0]      cmd_q;
	ptb_pkg::ident_t id_q;
	ptb_pkg::slot_t  idx_q;
	logic            found_q;

	// timer bank state outside the ram
	logic [ptb_pkg::NUM_TIMERS-1:0] active_q;
	ptb_pkg::ident_t                last_ident_q;
	ptb_pkg::slot_t                 service_q;
	ptb_pkg::count_t                delay_q;

	// read pipeline
	logic            rd_vld_s1;
	ptb_pkg::slot_t  rd_idx_s1;
	ptb_pkg::entry_t rdata_s1;

	logic          done_q;
	ptb_pkg::rsp_t result_q;

	// combinational
	logic                       accept;
	logic [ptb_pkg::SLOT_BITS:0] free_srch, chk_srch;
	logic                       free_found, chk_found;
	ptb_pkg::slot_t             free_slot, chk_slot, service_nxt;
	ptb_pkg::ident_t            ident_nxt;
	ptb_pkg::count_t            period_in, delay_nxt;
	logic                       walk_cmd, last_rd;
	logic                       hit_tick, hit_fire, hit_rm;
	ptb_pkg::ram_wr_t           ram_wr;
	ptb_pkg::ram_rd_t           ram_rd;
	ptb_pkg::rsp_t              imm_rsp, fin_rsp;

	assign busy   = (state_q != ptb_pkg::ST_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = result_q;

	// slot searches on the active bits (flip-flops, stable while idle)
	assign free_srch  = ptb_pkg::lowest_free(active_q);
	assign free_found = free_srch[ptb_pkg::SLOT_BITS];
	assign free_slot  = free_srch[ptb_pkg::SLOT_BITS-1:0];
	assign chk_srch   = ptb_pkg::ring_first(active_q, service_q);
	assign chk_found  = chk_srch[ptb_pkg::SLOT_BITS];
	assign chk_slot   = chk_srch[ptb_pkg::SLOT_BITS-1:0];

	// pointer moves just past the served slot
	assign service_nxt = (chk_slot == ptb_pkg::SLOT_BITS'(ptb_pkg::NUM_TIMERS - 1))
		? '0 : chk_slot + 1'b1;

	// fresh id, zero is skipped on wrap
	assign ident_nxt = (last_ident_q == '1) ? ptb_pkg::ID_BITS'(1) : last_ident_q + 1'b1;

	assign period_in = ptb_pkg::COUNT_BITS'(request.period);

	// commands that need the ram walk
	assign walk_cmd = (request.command == ptb_pkg::CMD_TICK)
		|| (request.command == ptb_pkg::CMD_REMOVE)
		|| ((request.command == ptb_pkg::CMD_CHECK) && chk_found);

	// check reads one slot, tick and remove read them all
	assign last_rd = (cmd_q == ptb_pkg::CMD_CHECK)
		|| (idx_q == ptb_pkg::SLOT_BITS'(ptb_pkg::NUM_TIMERS - 1));

	// delay counter after this request
	always_comb begin
		delay_nxt = delay_q;
		case (request.command)
			ptb_pkg::CMD_TICK:  if (delay_q != '0) delay_nxt = delay_q - 1'b1;
			ptb_pkg::CMD_DELAY: delay_nxt = ptb_pkg::COUNT_BITS'(request.delay_ticks);
			default:            delay_nxt = delay_q;
		endcase
	end

	// stage 1: act on the entry the ram just returned
	assign hit_tick = rd_vld_s1 && (cmd_q == ptb_pkg::CMD_TICK)
		&& active_q[rd_idx_s1] && (rdata_s1.count != '0);
	// check only ever reads an active slot
	assign hit_fire = rd_vld_s1 && (cmd_q == ptb_pkg::CMD_CHECK)
		&& (rdata_s1.count == '0);
	// first active match only, lowest slot wins on duplicate ids
	assign hit_rm   = rd_vld_s1 && (cmd_q == ptb_pkg::CMD_REMOVE) && !found_q
		&& active_q[rd_idx_s1] && (rdata_s1.ident == id_q);

	// ram write port: add writes at accept, tick and check write back at stage 1;
	// a walk reads slot n+1 while slot n is written, so no entry overlaps
	always_comb begin
		ram_wr = '0;
		if (accept && (request.command == ptb_pkg::CMD_ADD) && free_found) begin
			ram_wr.en   = 1'b1;
			ram_wr.addr = free_slot;
			ram_wr.data = '{period: period_in, count: period_in, ident: ident_nxt};
		end else if (hit_tick) begin
			ram_wr.en   = 1'b1;
			ram_wr.addr = rd_idx_s1;
			ram_wr.data = '{period: rdata_s1.period, count: rdata_s1.count - 1'b1,
				ident: rdata_s1.ident};
		end else if (hit_fire) begin
			// reload from the period
			ram_wr.en   = 1'b1;
			ram_wr.addr = rd_idx_s1;
			ram_wr.data = '{period: rdata_s1.period, count: rdata_s1.period,
				ident: rdata_s1.ident};
		end
	end

	ptb_slot_ram u_ram (
		.clk   (clk),
		.wr    (ram_wr),
		.rd    (ram_rd),
		.rdata (rdata_s1)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptb_pkg::ST_IDLE: if (accept && walk_cmd) state_d = ptb_pkg::ST_READ;
			ptb_pkg::ST_READ: if (last_rd) state_d = ptb_pkg::ST_LAST;
			ptb_pkg::ST_LAST: state_d = ptb_pkg::ST_IDLE;
			default:          state_d = ptb_pkg::ST_IDLE;
		endcase
	end

	// state outputs: one ram read per cycle while walking
	always_comb begin
		ram_rd = '0;
		unique case (state_q)
			ptb_pkg::ST_READ: begin
				ram_rd.en   = 1'b1;
				ram_rd.addr = idx_q;
			end
			ptb_pkg::ST_IDLE,
			ptb_pkg::ST_LAST: ram_rd = '0;
			default:          ram_rd = '0;
		endcase
	end

	// result of a request finished at accept
	always_comb begin
		imm_rsp            = '0;
		imm_rsp.delay_busy = (delay_nxt != '0);
		if (request.command == ptb_pkg::CMD_ADD) begin
			if (free_found) imm_rsp.assigned_id = ident_nxt;
			else            imm_rsp.status      = ptb_pkg::STAT_FULL;
		end
	end

	// result of a walk, formed with the last entry read
	always_comb begin
		fin_rsp            = '0;
		fin_rsp.delay_busy = (delay_q != '0);
		case (cmd_q)
			ptb_pkg::CMD_CHECK: begin
				fin_rsp.fired    = hit_fire;
				fin_rsp.fired_id = hit_fire ? rdata_s1.ident : '0;
			end
			ptb_pkg::CMD_REMOVE: begin
				fin_rsp.status = (found_q || hit_rm) ? ptb_pkg::STAT_OK
					: ptb_pkg::STAT_NOT_FOUND;
			end
			default: fin_rsp.status = ptb_pkg::STAT_OK;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ptb_pkg::ST_IDLE;
			active_q     <= '0;
			last_ident_q <= '0;
			service_q    <= '0;
			delay_q      <= '0;
			done_q       <= 1'b0;
			rd_vld_s1    <= 1'b0;
			found_q      <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= ram_rd.en;
			done_q    <= (accept && !walk_cmd) || (state_q == ptb_pkg::ST_LAST);
			if (accept) begin
				delay_q <= delay_nxt;
				found_q <= 1'b0;
				if ((request.command == ptb_pkg::CMD_ADD) && free_found) begin
					active_q[free_slot] <= 1'b1;
					last_ident_q        <= ident_nxt;
				end
				if ((request.command == ptb_pkg::CMD_CHECK) && chk_found)
					service_q <= service_nxt;
			end
			if (hit_rm) begin
				active_q[rd_idx_s1] <= 1'b0;
				found_q             <= 1'b1;
			end
		end
	end

	// request and pipeline payload
	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
		if (accept) begin
			cmd_q <= request.command;
			id_q  <= request.timer_id;
			idx_q <= (request.command == ptb_pkg::CMD_CHECK) ? chk_slot : '0;
		end else if (ram_rd.en && !last_rd) begin
			idx_q <= idx_q + 1'b1;
		end
		if (accept && !walk_cmd)              result_q <= imm_rsp;
		else if (state_q == ptb_pkg::ST_LAST) result_q <= fin_rsp;
	end

endmodule

>>> hw/rtl/ptb_checker.sv
// ----------------------------------------------------------------------------
// ptb_checker
// Port-level checks on the periodic timer bank, bound to the top level.
// ----------------------------------------------------------------------------
module ptb_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input ptb_pkg::req_t request,
	input logic          done,
	input ptb_pkg::rsp_t result
);

	// an accepted request is either in progress or answered next cycle
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted request neither busy nor done");

	// no result without an accepted request
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !start) |=> !done)
		else $error("result strobe with no request");

	// status is never the unused code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status != 2'd3))
		else $error("status holds an unused code");

	// a fired timer has a nonzero id and assigns nothing
	a_fired_id: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.fired) |-> ((result.fired_id != '0) && (result.assigned_id == '0)))
		else $error("fired result with bad ids");

	// a new id comes only with an ok status
	a_assign_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.assigned_id != '0)) |-> (result.status == ptb_pkg::STAT_OK))
		else $error("id assigned with error status");

endmodule

bind periodic_timer_bank ptb_checker u_ptb_checker (.*);
